// ===== rtl/srs_pkg.sv =====
// Shared types and register codes for the symmetry representative search
package srs_pkg;

	localparam logic [3:0] REG_SITES_IN_USE = 4'd0;
	localparam logic [3:0] REG_MAPS_IN_USE  = 4'd1;

	localparam logic ACT_QUERY = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	typedef struct packed {
		logic        valid;
		logic        action;
		logic [31:0] up;
		logic [31:0] dn;
		logic [31:0] ru;
		logic [31:0] rd;
		logic [3:0]  mi;
		logic [4:0]  si;
		logic [4:0]  ts;
	} beat_t;

endpackage

// ===== rtl/srs_if.sv =====
// Handshake channel interfaces for query, result and configuration beats
interface srs_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] up_word;
	logic [31:0] down_word;
	logic [3:0]  map_index;
	logic [4:0]  site_index;
	logic [4:0]  target_site;
	modport source (output valid, action, up_word, down_word, map_index, site_index,
		target_site, input ready);
	modport sink (input valid, action, up_word, down_word, map_index, site_index,
		target_site, output ready);
endinterface

interface srs_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] rep_up;
	logic [31:0] rep_down;
	logic        is_representative;
	modport source (output valid, rep_up, rep_down, is_representative, input ready);
	modport sink (input valid, rep_up, rep_down, is_representative, output ready);
endinterface

interface srs_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/srs_stage.sv =====
// One pipeline stage: holds one site map and applies it to the passing beat
module srs_stage #(
	parameter int LATTICE_SITES = 32,
	parameter int STAGE_IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [5:0]    nsites,
	input  logic [4:0]    nmaps,
	input  srs_pkg::beat_t beat_in,
	output srs_pkg::beat_t beat_s1
);
	localparam int TD = (LATTICE_SITES < 32) ? LATTICE_SITES : 32;
	localparam int IW = (TD > 1) ? $clog2(TD) : 1;

	logic [4:0]  map_q [TD];
	logic [31:0] nu, nd;
	logic        hit, active, wr;
	srs_pkg::beat_t nxt;
	srs_pkg::beat_t data_s1;
	logic        valid_s1;

	assign wr = advance && beat_in.valid && beat_in.action == srs_pkg::ACT_WRITE &&
		{3'b000, beat_in.mi} == 7'(STAGE_IDX) && {1'b0, beat_in.si} < 6'(TD);

	always_ff @(posedge clk) begin
		if (wr) begin
			map_q[beat_in.si[IW-1:0]] <= beat_in.ts;
		end
	end

	always_comb begin
		nu = '0;
		nd = '0;
		for (int j = 0; j < TD; j++) begin
			if (6'(j) < nsites) begin
				if (beat_in.up[j]) nu = nu | (32'd1 << map_q[j]);
				if (beat_in.dn[j]) nd = nd | (32'd1 << map_q[j]);
			end
		end
		active = 7'(STAGE_IDX) < {2'b00, nmaps};
		hit = active && beat_in.action == srs_pkg::ACT_QUERY &&
			({nu, nd} < {beat_in.ru, beat_in.rd});
		nxt = beat_in;
		if (hit) begin
			nxt.ru = nu;
			nxt.rd = nd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= beat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s1 <= nxt;
		end
	end

	always_comb begin
		beat_s1 = data_s1;
		beat_s1.valid = valid_s1;
	end
endmodule

// ===== rtl/symmetry_representative_search.sv =====
// Top level: config registers, chain of map stages and result register
// Each map has its own stage and table slice; a beat passes every stage
// register, then the result register. One beat per cycle unless rsp stalls.
// Table writes travel down the chain and land in their map's stage in order.
// Reset clears valid bits and sets sites_in_use to 32, maps_in_use to 0.
// The map table is not cleared by reset.
module symmetry_representative_search #(
	parameter int LATTICE_SITES = 32,
	parameter int NUM_MAPS  = 16
) (
	input logic clk,
	input logic arst_n,
	srs_req_if.sink   req,
	srs_rsp_if.source rsp,
	srs_cfg_if.sink   cfg
);
	logic [5:0] sites_q;
	logic [4:0] maps_q;
	logic [5:0] nsites;
	logic       advance;
	srs_pkg::beat_t chain [NUM_MAPS+1];
	logic        out_valid_q;
	logic [31:0] out_up_q, out_dn_q;
	logic        out_rep_q;

	assign cfg.ready = 1'b1;
	assign advance = !out_valid_q || rsp.ready;
	assign req.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sites_q <= 6'd32;
			maps_q  <= 5'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				srs_pkg::REG_SITES_IN_USE: sites_q <= cfg.data[5:0];
				srs_pkg::REG_MAPS_IN_USE:  maps_q  <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		nsites = sites_q;
		if ({1'b0, nsites} > 7'(LATTICE_SITES)) nsites = 6'(LATTICE_SITES);
		if (nsites > 6'd32) nsites = 6'd32;
	end

	assign chain[0] = '{
		valid:  req.valid,
		action: req.action,
		up:     req.up_word,
		dn:     req.down_word,
		ru:     req.up_word,
		rd:     req.down_word,
		mi:     req.map_index,
		si:     req.site_index,
		ts:     req.target_site
	};

	for (genvar g = 0; g < NUM_MAPS; g++) begin : g_stage
		srs_stage #(.LATTICE_SITES(LATTICE_SITES), .STAGE_IDX(g)) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.nsites  (nsites),
			.nmaps   (maps_q),
			.beat_in (chain[g]),
			.beat_s1 (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= chain[NUM_MAPS].valid &&
				chain[NUM_MAPS].action == srs_pkg::ACT_QUERY;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_up_q  <= chain[NUM_MAPS].ru;
			out_dn_q  <= chain[NUM_MAPS].rd;
			out_rep_q <= chain[NUM_MAPS].ru == chain[NUM_MAPS].up &&
				chain[NUM_MAPS].rd == chain[NUM_MAPS].dn;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.rep_up            = out_up_q;
	assign rsp.rep_down          = out_dn_q;
	assign rsp.is_representative = out_rep_q;

	a_first_stage: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> chain[1].valid)
		else $error("accepted beat missing from first stage");
	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(chain[1].valid) && $stable(out_valid_q))
		else $error("pipeline moved during stall");
	a_rep_flag: assert property (@(posedge clk) disable iff (!arst_n)
		advance && chain[NUM_MAPS].valid && chain[NUM_MAPS].action == srs_pkg::ACT_WRITE
		|=> !out_valid_q)
		else $error("table write produced a result");
endmodule
